[rtl/tuc_pkg.sv]
// ----------------------------------------------------------------------------
// tuc_pkg
// shared types and constants of the trip unit converter
// ----------------------------------------------------------------------------
package tuc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RegW   = 16;
  localparam int unsigned DivSteps = DataW;
  localparam logic [DataW-1:0] RecipScale = 32'd100000000;
  localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};

  typedef enum logic [3:0] {
    REG_KM_MILE_MUL    = 4'd0,
    REG_KM_MILE_DIV    = 4'd1,
    REG_EV_KM_MILE_MUL = 4'd2,
    REG_EV_KM_MILE_DIV = 4'd3,
    REG_US_GALLON_MUL  = 4'd4,
    REG_US_GALLON_DIV  = 4'd5,
    REG_UK_GALLON_MUL  = 4'd6,
    REG_UK_GALLON_DIV  = 4'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_PASS    = 2'd0,
    MODE_RECIP   = 2'd1,
    MODE_RATIO   = 2'd2,
    MODE_INVALID = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_FUEL     = 3'd0,
    KIND_HYDROGEN = 3'd1,
    KIND_INST_EL  = 3'd2,
    KIND_AVG_EL   = 3'd3,
    KIND_SPEED    = 3'd4,
    KIND_DIST     = 3'd5,
    KIND_EV_DIST  = 3'd6,
    KIND_NONE     = 3'd7
  } kind_t;

  // target unit codes, meaning depends on the kind
  typedef enum logic [2:0] {
    UNIT_BASE        = 3'd0,
    UNIT_PER100_MILE = 3'd1,
    UNIT_MPG_US_MI   = 3'd2,
    UNIT_MPG_UK      = 3'd3,
    UNIT_KM_UK_GAL   = 3'd4
  } unit_t;

  typedef struct packed {
    logic             valid;
    logic             done;
    logic             ok;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] lo;
    logic [DataW-1:0] d;
  } div_beat_t;

endpackage

[rtl/tuc_div_stage.sv]
// ----------------------------------------------------------------------------
// tuc_div_stage
// one registered step of the restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tuc_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tuc_pkg::div_beat_t din,
  output tuc_pkg::div_beat_t dout
);

  logic [tuc_pkg::DataW:0]   trial;
  logic [tuc_pkg::DataW:0]   diff;
  logic                      qbit;
  tuc_pkg::div_beat_t        dout_next;

  always_comb begin
    trial = {din.rem, din.lo[tuc_pkg::DataW-1]};
    diff  = trial - {1'b0, din.d};
    qbit  = (trial >= {1'b0, din.d});
    dout_next = din;
    if (!din.done) begin
      dout_next.rem = qbit ? diff[tuc_pkg::DataW-1:0] : trial[tuc_pkg::DataW-1:0];
      dout_next.lo  = {din.lo[tuc_pkg::DataW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

[rtl/trip_unit_converter.sv]
// ----------------------------------------------------------------------------
// trip_unit_converter
// converts a trip-computer quantity from its base unit to a display unit
// ----------------------------------------------------------------------------
// One beat in per cycle unless stalled, one result beat out per input beat, in
// order. Three stages decode the unit, form the ratio products (16x16 then 32x32
// multiply) and handle special cases, then a 32-stage restoring divider yields
// one quotient bit per stage. The whole pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Ratio registers are written through the cfg channel, which is always ready.
module trip_unit_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // req_type[2:0], unit_code[5:3], value[37:6], allow_approx[38]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // converted[31:0]
  output logic        m_tuser,   // valid_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned W = tuc_pkg::DataW;
  localparam int unsigned R = tuc_pkg::RegW;

  logic [R-1:0] km_mul, km_div, ev_mul, ev_div, us_mul, us_div, uk_mul, uk_div;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      km_mul <= 16'd1000;
      km_div <= 16'd1609;
      ev_mul <= 16'd1000;
      ev_div <= 16'd1609;
      us_mul <= 16'd3785;
      us_div <= 16'd1000;
      uk_mul <= 16'd4546;
      uk_div <= 16'd1000;
    end else if (cfg_valid) begin
      case (tuc_pkg::reg_idx_t'(cfg_index))
        tuc_pkg::REG_KM_MILE_MUL:    km_mul <= cfg_data;
        tuc_pkg::REG_KM_MILE_DIV:    km_div <= cfg_data;
        tuc_pkg::REG_EV_KM_MILE_MUL: ev_mul <= cfg_data;
        tuc_pkg::REG_EV_KM_MILE_DIV: ev_div <= cfg_data;
        tuc_pkg::REG_US_GALLON_MUL:  us_mul <= cfg_data;
        tuc_pkg::REG_US_GALLON_DIV:  us_div <= cfg_data;
        tuc_pkg::REG_UK_GALLON_MUL:  uk_mul <= cfg_data;
        tuc_pkg::REG_UK_GALLON_DIV:  uk_div <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  tuc_pkg::div_beat_t chain [tuc_pkg::DivSteps+1];

  assign en       = !chain[tuc_pkg::DivSteps].valid || m_tready;
  assign s_tready = en;

  // stage 1: decode, ratio products
  tuc_pkg::kind_t kind;
  logic [2:0]     unit;
  logic [W-1:0]   in_value;
  tuc_pkg::mode_t mode_next;
  logic [R-1:0]   ma, mb, da, db;

  assign kind     = tuc_pkg::kind_t'(s_tdata[2:0]);
  assign unit     = s_tdata[5:3];
  assign in_value = s_tdata[37:6];

  always_comb begin
    mode_next = tuc_pkg::MODE_RATIO;
    ma = km_mul;
    mb = 16'd1;
    da = km_div;
    db = 16'd1;
    if (unit == tuc_pkg::UNIT_BASE && kind != tuc_pkg::KIND_NONE) begin
      mode_next = tuc_pkg::MODE_PASS;
    end else if (unit == tuc_pkg::UNIT_PER100_MILE
                 && (kind == tuc_pkg::KIND_FUEL || kind == tuc_pkg::KIND_HYDROGEN
                 || kind == tuc_pkg::KIND_INST_EL || kind == tuc_pkg::KIND_AVG_EL)) begin
      mode_next = tuc_pkg::MODE_RECIP;
    end else if (kind == tuc_pkg::KIND_FUEL && unit == tuc_pkg::UNIT_MPG_US_MI) begin
      mb = us_mul;
      db = us_div;
    end else if (kind == tuc_pkg::KIND_FUEL && unit == tuc_pkg::UNIT_MPG_UK) begin
      mb = uk_mul;
      db = uk_div;
    end else if (kind == tuc_pkg::KIND_FUEL && unit == tuc_pkg::UNIT_KM_UK_GAL) begin
      ma = uk_mul;
      da = uk_div;
    end else if ((kind == tuc_pkg::KIND_HYDROGEN || kind == tuc_pkg::KIND_INST_EL)
                 && unit == tuc_pkg::UNIT_MPG_US_MI) begin
      ma = km_mul;
    end else if (kind == tuc_pkg::KIND_AVG_EL && unit == tuc_pkg::UNIT_MPG_US_MI) begin
      ma = ev_mul;
      da = ev_div;
    end else if ((kind == tuc_pkg::KIND_SPEED || kind == tuc_pkg::KIND_DIST)
                 && unit == tuc_pkg::UNIT_PER100_MILE) begin
      ma = km_mul;
    end else if (kind == tuc_pkg::KIND_EV_DIST && unit == tuc_pkg::UNIT_PER100_MILE) begin
      ma = ev_mul;
      da = ev_div;
    end else begin
      mode_next = tuc_pkg::MODE_INVALID;
    end
  end

  logic           p1_valid;
  tuc_pkg::mode_t p1_mode;
  logic [W-1:0]   p1_value, p1_m, p1_d;
  logic           p1_approx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= s_tvalid;
      p1_mode   <= mode_next;
      p1_value  <= in_value;
      p1_approx <= s_tdata[38];
      p1_m      <= ma * mb;
      p1_d      <= da * db;
    end
  end

  // stage 2: wide product
  logic           p2_valid;
  tuc_pkg::mode_t p2_mode;
  logic [W-1:0]   p2_value, p2_d;
  logic [2*W-1:0] p2_n;
  logic           p2_approx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid  <= p1_valid;
      p2_mode   <= p1_mode;
      p2_value  <= p1_value;
      p2_approx <= p1_approx;
      p2_d      <= p1_d;
      p2_n      <= {{W{1'b0}}, p1_value} * {{W{1'b0}}, p1_m};
    end
  end

  // stage 3: special cases and divider entry
  tuc_pkg::div_beat_t entry;

  always_comb begin
    entry.valid = p2_valid;
    entry.done  = 1'b1;
    entry.ok    = 1'b1;
    entry.rem   = '0;
    entry.lo    = p2_value;
    entry.d     = p2_d;
    case (p2_mode)
      tuc_pkg::MODE_PASS: ;
      tuc_pkg::MODE_RECIP: begin
        if (p2_value == '0) begin
          entry.lo = p2_approx ? tuc_pkg::AllOnes : '0;
        end else begin
          entry.done = 1'b0;
          entry.lo   = tuc_pkg::RecipScale;
          entry.d    = p2_value;
        end
      end
      tuc_pkg::MODE_RATIO: begin
        if (p2_value == '0) begin
          entry.lo = '0;
        end else if (p2_d == '0 || p2_n[2*W-1:W] >= p2_d) begin
          entry.lo = tuc_pkg::AllOnes;
        end else begin
          entry.done = 1'b0;
          entry.rem  = p2_n[2*W-1:W];
          entry.lo   = p2_n[W-1:0];
        end
      end
      default: entry.ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0] <= entry;
    end
  end

  for (genvar i = 0; i < tuc_pkg::DivSteps; i++) begin : g_div
    tuc_div_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  assign m_tvalid = chain[tuc_pkg::DivSteps].valid;
  assign m_tdata  = chain[tuc_pkg::DivSteps].lo;
  assign m_tuser  = chain[tuc_pkg::DivSteps].ok;

endmodule
